### rtl/nns_pkg.sv
// Package for the nearest neighbor select unit: sizes, word types, cell control,
// FSM states and configuration register codes.
// No dependencies.
package nns_pkg;

    localparam int CAPACITY  = 32;
    localparam int MAX_NODES = 4096;

    localparam int IDX_W  = 12;
    localparam int DIST_W = 23;
    localparam int MODE_W = 2;
    localparam int K_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // kept count runs 0..CAPACITY
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    // cell address runs 0..CAPACITY-1
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [MODE_W-1:0] MODE_STANDARD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KNN      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOUNDED  = 2'd2;

    localparam logic [MODE_W-1:0]     RST_MODE  = MODE_STANDARD;
    localparam logic [K_W-1:0]        RST_K     = 6'd8;
    localparam logic [DIST_W-1:0]     RST_LIMIT = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METRIC_MODE    = 2'd0,
        CFG_NEIGHBOR_COUNT = 2'd1,
        CFG_DISTANCE_LIMIT = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        ST_COLLECT = 1'b0,
        ST_DRAIN   = 1'b1
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]  node_index;
        logic [IDX_W-1:0]  center_index;
        logic [DIST_W-1:0] distance;
        logic              last_item;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]  neighbor_index;
        logic [DIST_W-1:0] neighbor_distance;
        logic              last_result;
        logic              empty_list;
        logic              overflowed;
    } t_out_word;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
    } t_entry;

    // broadcast to every cell each cycle
    typedef struct packed {
        logic   insert;
        logic   shift;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

### rtl/nearest_neighbor_select_unit.sv
// Nearest neighbor select unit: top level with control, config registers,
// the insertion chain of nns_cell slots and the output register.
// Depends on nns_pkg and nns_cell.
//
// Input channel (i_in / i_in_valid / o_in_ready): one distance-row word per
// cycle. A word whose node equals the center or lies out of range is skipped,
// but its last_item mark still counts. Each accepted word is compared against
// all kept slots at once and inserted in place.
// After the word with last_item, input is held off while the kept list drains
// nearest first, one result word per cycle while the receiver keeps up (count
// results, or one empty marker). The word with last_item moves the FSM into
// drain, and the first result is then loaded into the output register; the
// single output register and the one-slot left shift per result set the drain
// rate.
// Receiver stall: the output register holds its word and the chain stops
// shifting. The next row may start while the final result still waits.
// Config port (i_cfg_*) is always ready; writes to index 3 are ignored.
// Reset (i_rst_n low, synchronous) empties the list, clears the overflow flag
// and output valid, and loads mode standard, k = 8, limit = max. Slot
// contents are not cleared; only slots below the count are ever read.
module nearest_neighbor_select_unit
    import nns_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  t_in_word              i_in,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,

    output t_out_word             o_out,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ---------------- state ----------------
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [MODE_W-1:0]   r_mode;
    logic [K_W-1:0]      r_k;
    logic [DIST_W-1:0]   r_limit;
    t_out_word           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // ---------------- handshake ----------------
    logic in_fire;
    logic drain_load;
    logic cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: begin
                if (in_fire && i_in.last_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // the last result of the row leaves when count is 0 or 1
                if (drain_load && (r_count <= CNT_W'(1))) begin
                    n_state = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        drain_load = 1'b0;
        case (r_state)
            ST_COLLECT: o_in_ready = 1'b1;
            ST_DRAIN:   drain_load = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                drain_load = 1'b0;
            end
        endcase
    end

    // ---------------- candidate qualification ----------------
    logic              node_ok;
    logic              consider;
    logic              cap_bound;
    logic [CNT_W-1:0]  room;
    logic              pos_ge_room;
    logic              list_full;
    logic              do_insert;
    logic [CAPACITY-1:0] le;

    assign node_ok = (i_in.node_index != i_in.center_index) &&
                     (32'(i_in.node_index) < MAX_NODES);

    always_comb begin
        room      = CNT_W'(CAPACITY);
        cap_bound = 1'b1;
        consider  = in_fire && node_ok;
        if (r_mode == MODE_KNN) begin
            if (32'(r_k) <= CAPACITY) begin
                room      = CNT_W'(r_k);
                cap_bound = 1'b0;
            end
        end else if (r_mode == MODE_BOUNDED) begin
            if (i_in.distance > r_limit) begin
                consider = 1'b0;
            end
        end
    end

    // kept slots that compare <= form a prefix, so the insert point is at or
    // beyond room exactly when slot room-1 keeps its place
    assign pos_ge_room = (room == '0) || le[SLOT_W'(room - CNT_W'(1))];
    assign list_full   = (r_count >= room);
    assign do_insert   = consider && !pos_ge_room;

    // ---------------- cell chain ----------------
    t_cell_ctl cell_ctl;
    t_entry    cell_q [CAPACITY];

    assign cell_ctl.insert             = do_insert;
    assign cell_ctl.shift              = drain_load && (r_count != '0);
    assign cell_ctl.new_entry.index    = i_in.node_index;
    assign cell_ctl.new_entry.distance = i_in.distance;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   left_le;
        t_entry left_q;
        t_entry right_q;
        if (g == 0) begin : g_head
            assign left_le = 1'b1;
            assign left_q  = cell_ctl.new_entry;
        end else begin : g_body
            assign left_le = le[g-1];
            assign left_q  = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_q = cell_q[g];
        end else begin : g_mid
            assign right_q = cell_q[g+1];
        end
        nns_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_valid   (CNT_W'(g) < r_count),
            .i_left_le (left_le),
            .i_left    (left_q),
            .i_right   (right_q),
            .o_le      (le[g]),
            .o_entry   (cell_q[g])
        );
    end

    // ---------------- count and overflow ----------------
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (drain_load) begin
            if (r_count <= CNT_W'(1)) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end else begin
            if (do_insert) begin
                n_count = list_full ? room : (r_count + CNT_W'(1));
            end
            if (consider && cap_bound && (pos_ge_room || list_full)) begin
                n_ovf = 1'b1;
            end
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (drain_load) begin
            n_out_valid = 1'b1;
            n_out.overflowed = r_ovf;
            if (r_count == '0) begin
                n_out.neighbor_index    = '0;
                n_out.neighbor_distance = '0;
                n_out.last_result       = 1'b1;
                n_out.empty_list        = 1'b1;
            end else begin
                n_out.neighbor_index    = cell_q[0].index;
                n_out.neighbor_distance = cell_q[0].distance;
                n_out.last_result       = (r_count == CNT_W'(1));
                n_out.empty_list        = 1'b0;
            end
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_k     <= RST_K;
            r_limit <= RST_LIMIT;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                CFG_METRIC_MODE:    r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_NEIGHBOR_COUNT: r_k     <= i_cfg_data[K_W-1:0];
                CFG_DISTANCE_LIMIT: r_limit <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- assertions ----------------
`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("kept count beyond capacity");

    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.last_item) |=> (r_state == ST_DRAIN))
        else $error("row end did not start drain");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drain_load && (r_count <= CNT_W'(1))) |=>
            (r_count == '0) && !r_ovf && o_out_valid && o_out.last_result)
        else $error("final result did not clear the list");

    a_no_insert_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !o_in_ready && !do_insert)
        else $error("input taken during drain");
`endif

endmodule

### rtl/nns_cell.sv
// One slot of the sorted insertion chain: holds an entry, compares it against
// the broadcast candidate, and takes the candidate or data from its left or right neighbor.
// Depends on nns_pkg.
module nns_cell
    import nns_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,     // slot lies below the kept count
    input  logic      i_left_le,   // left neighbor keeps its place
    input  t_entry    i_left,
    input  t_entry    i_right,
    output logic      o_le,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // ties stay ahead of the newcomer
    assign o_le    = i_valid && (r_entry.distance <= i_ctl.new_entry.distance);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_right;
        end else if (i_ctl.insert && !o_le) begin
            n_entry = i_left_le ? i_ctl.new_entry : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
